FILE: sv/ibd_pkg.sv
// Shared widths and register indexes for the image box downscaler.
package ibd_pkg;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int DIV_W      = 14;
  localparam int SUM_W      = 32;
  localparam int FF_W       = 26;
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_CHAN   = 4;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_CHAN;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int CIDX_W     = 3;

  localparam logic [CIDX_W-1:0] REG_SRC_W = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SRC_H = 3'd1;
  localparam logic [CIDX_W-1:0] REG_TGT_W = 3'd2;
  localparam logic [CIDX_W-1:0] REG_TGT_H = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BPP   = 3'd4;

  localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;
endpackage

FILE: sv/ibd_ram.sv
// Generic single-port-write, registered-read RAM.
module ibd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: sv/ibd_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ibd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ibd_pkg::DIV_W-1:0] dividend,
  input  logic [ibd_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ibd_pkg::DIV_W-1:0] quot
);
  localparam int CNT_W = $clog2(ibd_pkg::DIV_W + 1);

  logic [ibd_pkg::DIV_W:0]   rem_r, rem_nxt, rem_sh;
  logic [ibd_pkg::DIV_W-1:0] q_r, q_nxt, d_r;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    rem_sh   = {rem_r[ibd_pkg::DIV_W-1:0], q_r[ibd_pkg::DIV_W-1]};
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CNT_W'(ibd_pkg::DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, d_r}) begin
        rem_nxt = rem_sh - {1'b0, d_r};
        q_nxt   = {q_r[ibd_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[ibd_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      d_r <= divisor;
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

FILE: sv/image_box_downscale.sv
// Top level of the integer box-filter image downscaler.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | in_pixel_byte
//   out_    | output    | out_valid/stall  | average, column, row, channel, frame_last
//   cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// A byte is accepted in idle, then its accumulator is read-modify-written through the
// registered-read sum memory; after a block's last byte the compare-subtract loop forms
// sum/(f*f) and the output register is loaded, after any wait on a full output
// register. in_stall holds further bytes until the sequencer is idle again.
// After reset and after each write to register index 0 to 4, the 14-bit serial divider
// derives f and the output size; no item is taken meanwhile.
// The sum memory needs no clearing: a block's first byte overwrites its entry.
module image_box_downscale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_pixel_byte,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_average_value,
  output logic [ibd_pkg::COORD_W-1:0]       out_column,
  output logic [ibd_pkg::COORD_W-1:0]       out_row,
  output logic [1:0]                        out_channel_index,
  output logic                              out_frame_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ibd_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [ibd_pkg::DIM_W-1:0]         cfg_data
);
  localparam int DW = ibd_pkg::DIM_W;
  localparam int XW = ibd_pkg::DIV_W;

  localparam logic [2:0] S_DSTART = 3'd0;
  localparam logic [2:0] S_DWAIT  = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_IDLE   = 3'd3;
  localparam logic [2:0] S_ACC    = 3'd4;
  localparam logic [2:0] S_AVG    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // configuration registers
  logic [DW-1:0] sw_r, sh_r, tw_r, th_r;
  logic [2:0]    bpp_r;
  logic          cfg_wr, cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_wr && (cfg_index <= ibd_pkg::REG_BPP);

  // effective sizes
  logic [DW-1:0] esw, esh, etw, eth;
  logic [1:0]    ch_last;
  always_comb begin
    esw = (sw_r == '0) ? DW'(1) :
          (sw_r > DW'(ibd_pkg::MAX_WIDTH)) ? DW'(ibd_pkg::MAX_WIDTH) : sw_r;
    esh = (sh_r == '0) ? DW'(1) :
          (sh_r > ibd_pkg::HEIGHT_LIMIT) ? ibd_pkg::HEIGHT_LIMIT : sh_r;
    etw = (tw_r == '0) ? DW'(1) : tw_r;
    eth = (th_r == '0) ? DW'(1) : th_r;
    ch_last = (bpp_r == 3'd3) ? 2'd2 : 2'd3;
  end

  // state
  logic [2:0]             state_r;
  logic [1:0]             step_r;
  logic [DW-1:0]          fx_r, f_r, ow_r, oh_r;
  logic [ibd_pkg::FF_W-1:0] ff_r;
  logic [DW-1:0]          x_r, y_r, xin_r, yin_r, bx_r, by_r;
  logic [1:0]             ch_r;

  // setup divider
  logic          div_start, div_done;
  logic [XW-1:0] div_a, div_b, div_q;

  always_comb begin
    case (step_r)
      2'd0:    begin div_a = XW'(esw) + XW'(etw) - XW'(1); div_b = XW'(etw); end
      2'd1:    begin div_a = XW'(esh) + XW'(eth) - XW'(1); div_b = XW'(eth); end
      2'd2:    begin div_a = XW'(esw); div_b = XW'(f_r); end
      default: begin div_a = XW'(esh); div_b = XW'(f_r); end
    endcase
  end
  assign div_start = (state_r == S_DSTART) && !cfg_hit;

  ibd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q)
  );

  // per-item classification from the counters
  logic                      acc, in_blk_valid, in_first, in_emit, in_last;
  logic [ibd_pkg::ADDR_W-1:0] in_addr;
  assign acc          = in_valid && !in_stall;
  assign in_blk_valid = (bx_r < ow_r) && (by_r < oh_r);
  assign in_first     = (xin_r == '0) && (yin_r == '0);
  assign in_emit      = (xin_r == f_r - 1'b1) && (yin_r == f_r - 1'b1);
  assign in_last      = (bx_r == ow_r - 1'b1) && (by_r == oh_r - 1'b1) && (ch_r == ch_last);
  assign in_addr      = {bx_r[ibd_pkg::ADDR_W-3:0], ch_r};
  assign in_stall     = (state_r != S_IDLE);

  // latched item
  logic [7:0]                 byte_r;
  logic [ibd_pkg::ADDR_W-1:0] addr_r;
  logic                       valid_r, first_r, emit_r, last_r;
  logic [DW-1:0]              obx_r, oby_r;
  logic [1:0]                 och_r;

  // sum memory
  logic [ibd_pkg::SUM_W-1:0] rd_data, sum;
  logic                      wr_en;
  assign sum   = (first_r ? '0 : rd_data) + ibd_pkg::SUM_W'(byte_r);
  assign wr_en = (state_r == S_ACC) && valid_r;

  ibd_ram #(.WIDTH(ibd_pkg::SUM_W), .DEPTH(ibd_pkg::MEM_DEPTH)) u_sums (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (sum),
    .rd_en   (acc),
    .rd_addr (in_addr),
    .rd_data (rd_data)
  );

  // average loop
  logic [ibd_pkg::SUM_W-1:0] rem_r, trial;
  logic [7:0]                q_r;
  logic [2:0]                k_r;
  assign trial = ibd_pkg::SUM_W'(ff_r) << k_r;

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DSTART;
      step_r  <= '0;
      sw_r    <= 13'd640;
      sh_r    <= 13'd480;
      tw_r    <= 13'd320;
      th_r    <= 13'd240;
      bpp_r   <= 3'd4;
      x_r <= '0; y_r <= '0; xin_r <= '0; yin_r <= '0; bx_r <= '0; by_r <= '0;
      ch_r    <= '0;
      f_r     <= DW'(1);
      ow_r    <= '0;
      oh_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken and none loaded behind it
      if (out_valid && !out_stall && !(state_r == S_OUT && !cfg_hit)) begin
        out_valid <= 1'b0;
      end
      if (cfg_hit) begin
        unique case (cfg_index)
          ibd_pkg::REG_SRC_W: sw_r  <= cfg_data;
          ibd_pkg::REG_SRC_H: sh_r  <= cfg_data;
          ibd_pkg::REG_TGT_W: tw_r  <= cfg_data;
          ibd_pkg::REG_TGT_H: th_r  <= cfg_data;
          default:            bpp_r <= cfg_data[2:0];
        endcase
        state_r <= S_DSTART;
        step_r  <= '0;
        x_r <= '0; y_r <= '0; xin_r <= '0; yin_r <= '0; bx_r <= '0; by_r <= '0;
        ch_r    <= '0;
      end else begin
        unique case (state_r)
          S_DSTART: state_r <= S_DWAIT;
          S_DWAIT: begin
            if (div_done) begin
              unique case (step_r)
                2'd0: fx_r <= div_q[DW-1:0];
                2'd1: begin
                  if (etw >= esw && eth >= esh) begin
                    f_r <= DW'(1);
                  end else begin
                    f_r <= (fx_r > div_q[DW-1:0]) ? fx_r : div_q[DW-1:0];
                  end
                end
                2'd2: ow_r <= div_q[DW-1:0];
                default: oh_r <= div_q[DW-1:0];
              endcase
              step_r  <= step_r + 1'b1;
              state_r <= (step_r == 2'd3) ? S_MUL : S_DSTART;
            end
          end
          S_MUL: begin
            ff_r    <= ibd_pkg::FF_W'(f_r * f_r);
            state_r <= S_IDLE;
          end
          S_IDLE: begin
            if (acc) begin
              state_r <= S_ACC;
              // advance the raster counters
              if (ch_r == ch_last) begin
                ch_r <= '0;
                if (x_r == esw - 1'b1) begin
                  x_r <= '0; xin_r <= '0; bx_r <= '0;
                  if (y_r == esh - 1'b1) begin
                    y_r <= '0; yin_r <= '0; by_r <= '0;
                  end else begin
                    y_r <= y_r + 1'b1;
                    if (yin_r == f_r - 1'b1) begin
                      yin_r <= '0;
                      by_r  <= by_r + 1'b1;
                    end else begin
                      yin_r <= yin_r + 1'b1;
                    end
                  end
                end else begin
                  x_r <= x_r + 1'b1;
                  if (xin_r == f_r - 1'b1) begin
                    xin_r <= '0;
                    bx_r  <= bx_r + 1'b1;
                  end else begin
                    xin_r <= xin_r + 1'b1;
                  end
                end
              end else begin
                ch_r <= ch_r + 1'b1;
              end
            end
          end
          S_ACC: begin
            rem_r <= sum;
            q_r   <= '0;
            k_r   <= 3'd7;
            state_r <= (valid_r && emit_r) ? S_AVG : S_IDLE;
          end
          S_AVG: begin
            if (rem_r >= trial) begin
              rem_r <= rem_r - trial;
              q_r   <= q_r | (8'd1 << k_r);
            end
            k_r <= k_r - 1'b1;
            if (k_r == 3'd0) begin
              state_r <= S_OUT;
            end
          end
          S_OUT: begin
            if (out_free) begin
              out_valid <= 1'b1;
              state_r   <= S_IDLE;
            end
          end
          default: state_r <= S_DSTART;
        endcase
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      byte_r  <= in_pixel_byte;
      addr_r  <= in_addr;
      valid_r <= in_blk_valid;
      first_r <= in_first;
      emit_r  <= in_emit;
      last_r  <= in_last;
      obx_r   <= bx_r;
      oby_r   <= by_r;
      och_r   <= ch_r;
    end
    if (state_r == S_OUT && out_free && !cfg_hit) begin
      out_average_value <= q_r;
      out_column        <= obx_r[ibd_pkg::COORD_W-1:0];
      out_row           <= oby_r[ibd_pkg::COORD_W-1:0];
      out_channel_index <= och_r;
      out_frame_last    <= last_r;
    end
  end
endmodule
